/* src/bifb_pkg.sv */
// ----------------------------------------------------------------------------
// bifb_pkg
// Shared types and constants for the boot info framebuffer tag finder.
// ----------------------------------------------------------------------------
package bifb_pkg;

  localparam int unsigned MAX_TOTAL_BYTES_DEF = 65536;
  localparam int unsigned OFF_W = 17;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NO_INFO   = 3'd1;
  localparam logic [2:0] ST_BAD_TOTAL = 3'd2;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd3;
  localparam logic [2:0] ST_UNUSABLE  = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  typedef struct packed {
    logic [31:0] data_word;
    logic        first_word;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] frame_address;
    logic [31:0] line_pitch;
    logic [31:0] pixel_width;
    logic [31:0] pixel_height;
  } result_t;

endpackage

/* src/boot_info_framebuffer_tag_finder.sv */
// ----------------------------------------------------------------------------
// boot_info_framebuffer_tag_finder
// Walks a boot info tag stream and reports the first framebuffer tag.
// ----------------------------------------------------------------------------
//  channel  | signals                           | dir | payload
//  item     | item_valid, item_stall, item      | in  | item_t (one 32-bit word)
//  result   | result_valid, result_stall, result| out | result_t (at most one per structure)
//  base     | base_valid, base_ready, base_data | in  | 64-bit info base pointer
//
//  One word per cycle while item_stall is low. The result is registered from the deciding word,
//  into the output register or, when that is occupied, the skid entry. A two-entry output
//  buffer (output register plus skid) holds results; item_stall rises only while the skid entry is full.
//  base_ready is always high; the pointer is captured whenever base_valid is high and checked on each first word.
//  rst is synchronous, active high, and clears the walk and the buffer.
// ----------------------------------------------------------------------------
module boot_info_framebuffer_tag_finder #(
  parameter int unsigned MAX_TOTAL_BYTES = bifb_pkg::MAX_TOTAL_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bifb_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bifb_pkg::result_t result,
  input  logic              base_valid,
  output logic              base_ready,
  input  logic [63:0]       base_data
);
  import bifb_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SEEK    = 3'd1;
  localparam logic [2:0] PH_SIZE    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [31:0] MaxTotal = 32'(MAX_TOTAL_BYTES);

  logic [63:0]      base_ptr;
  logic [2:0]       phase, phase_next;
  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic [OFF_W-1:0] total_bytes, total_bytes_next;
  logic [OFF_W-1:0] next_tag, next_tag_next;
  logic             tag_disp, tag_disp_next;
  logic [31:0]      cap_addr, cap_addr_next;
  logic             addr_hi_nz, addr_hi_nz_next;
  logic [31:0]      cap_pitch, cap_pitch_next;
  logic [31:0]      cap_width, cap_width_next;
  logic [31:0]      cap_height, cap_height_next;

  logic             skid_valid;
  result_t          skid;
  logic             accept, push, pop;
  logic [2:0]       push_status;
  result_t          push_word;

  logic [OFF_W-1:0] off_inc;
  logic [OFF_W-1:0] rel;
  logic [32:0]      rounded;
  logic [33:0]      tag_sum;
  logic [31:0]      word;

  assign base_ready = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;
  assign word       = item.data_word;

  assign off_inc = byte_offset + OFF_W'(4);
  assign rel     = off_inc - next_tag;
  assign rounded = ({1'b0, word} + 33'd7) & ~33'd7;
  assign tag_sum = {{(34-OFF_W){1'b0}}, next_tag} + {1'b0, rounded};

  always_comb begin
    phase_next       = phase;
    byte_offset_next = byte_offset;
    total_bytes_next = total_bytes;
    next_tag_next    = next_tag;
    tag_disp_next    = tag_disp;
    cap_addr_next    = cap_addr;
    addr_hi_nz_next  = addr_hi_nz;
    cap_pitch_next   = cap_pitch;
    cap_width_next   = cap_width;
    cap_height_next  = cap_height;
    push             = 1'b0;
    push_status      = ST_NONE;
    if (accept) begin
      if (item.first_word) begin
        byte_offset_next = '0;
        next_tag_next    = OFF_W'(8);
        tag_disp_next    = 1'b0;
        cap_addr_next    = '0;
        addr_hi_nz_next  = 1'b0;
        cap_pitch_next   = '0;
        cap_width_next   = '0;
        cap_height_next  = '0;
        if (base_ptr == 64'd0 || base_ptr[63:32] != 32'd0) begin
          push        = 1'b1;
          push_status = ST_NO_INFO;
        end else if (word < 32'd16 || word > MaxTotal) begin
          push        = 1'b1;
          push_status = ST_BAD_TOTAL;
        end else begin
          total_bytes_next = word[OFF_W-1:0];
          phase_next       = PH_SEEK;
        end
      end else if (phase inside {PH_SEEK, PH_SIZE, PH_PAYLOAD}) begin
        byte_offset_next = off_inc;
        case (phase)
          PH_SEEK: begin
            if (off_inc == next_tag) begin
              tag_disp_next = (word == 32'd8);
              phase_next    = PH_SIZE;
            end
          end
          PH_SIZE: begin
            if (word == 32'd0) begin
              push        = 1'b1;
              push_status = ST_ZERO_SIZE;
            end else if (tag_disp) begin
              phase_next = PH_PAYLOAD;
            end else if (tag_sum + 34'd8 > {{(34-OFF_W){1'b0}}, total_bytes}) begin
              push        = 1'b1;
              push_status = ST_NONE;
            end else begin
              next_tag_next = tag_sum[OFF_W-1:0];
              phase_next    = PH_SEEK;
            end
          end
          default: begin
            case (rel)
              OFF_W'(8):  cap_addr_next   = word;
              OFF_W'(12): addr_hi_nz_next = (word != 32'd0);
              OFF_W'(16): cap_pitch_next  = word;
              OFF_W'(20): cap_width_next  = word;
              OFF_W'(24): cap_height_next = word;
              OFF_W'(28): begin
                push        = 1'b1;
                push_status = (word[7:0] == 8'd32 && (cap_addr != 32'd0 || addr_hi_nz))
                              ? ST_FOUND : ST_UNUSABLE;
              end
              default: ;
            endcase
          end
        endcase
      end
      if (push) begin
        phase_next = PH_DONE;
      end
    end
  end

  always_comb begin
    push_word.status        = push_status;
    push_word.frame_address = (push_status == ST_FOUND) ? cap_addr   : 32'd0;
    push_word.line_pitch    = (push_status == ST_FOUND) ? cap_pitch  : 32'd0;
    push_word.pixel_width   = (push_status == ST_FOUND) ? cap_width  : 32'd0;
    push_word.pixel_height  = (push_status == ST_FOUND) ? cap_height : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_ptr    <= '0;
      phase       <= PH_IDLE;
      byte_offset <= '0;
      total_bytes <= '0;
      next_tag    <= OFF_W'(8);
      tag_disp    <= 1'b0;
      cap_addr    <= '0;
      addr_hi_nz  <= 1'b0;
      cap_pitch   <= '0;
      cap_width   <= '0;
      cap_height  <= '0;
    end else begin
      if (base_valid && base_ready) begin
        base_ptr <= base_data;
      end
      phase       <= phase_next;
      byte_offset <= byte_offset_next;
      total_bytes <= total_bytes_next;
      next_tag    <= next_tag_next;
      tag_disp    <= tag_disp_next;
      cap_addr    <= cap_addr_next;
      addr_hi_nz  <= addr_hi_nz_next;
      cap_pitch   <= cap_pitch_next;
      cap_width   <= cap_width_next;
      cap_height  <= cap_height_next;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end else if (push) begin
        result <= push_word;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (!result_valid) begin
      if (push) begin
        result       <= push_word;
        result_valid <= 1'b1;
      end
    end else if (push) begin
      skid       <= push_word;
      skid_valid <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry full while output register empty");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_FOUND) |->
      (result.frame_address == 32'd0 && result.line_pitch == 32'd0 &&
       result.pixel_width == 32'd0 && result.pixel_height == 32'd0))
    else $error("nonzero fields on a failed result");

  a_done_after_push: assert property (@(posedge clk) disable iff (rst)
    push |=> phase == PH_DONE)
    else $error("walk not closed after a result");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= ST_NONE)
    else $error("status code out of range");
`endif

endmodule
